### hw/rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/pts_pkg.sv
// Shared constants for the priority task scheduler.
package pts_pkg;

   localparam int SLEEP_W  = 16;
   localparam int MODE_W   = 2;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_QUEUED    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RUNNING   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SLEEPING  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SUSPENDED = 2'd3;

   localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DELAY   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SUSPEND = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOEFF  = 2'd2;

endpackage

### hw/rtl/pts_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module pts_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/priority_task_scheduler.sv
// Priority task scheduler: top level with event sequencer and ready queues.
//
// Channels: req_* takes one event word (kind in tuser, operands in tdata);
// rsp_* returns one result word per event with the running task, the slot
// of a new task and a status code.
// One event is worked at a time. Add and rejected events go from decode
// straight to the result. Suspend/resume read the task's entry; a suspend
// that removes the task then walks its ready queue, reading each entry and
// writing back those it keeps. A tick walks the task table (a read and a
// write step per added task); tick and delay requeue the running task, or a
// delay puts it to sleep, and then scan priority levels one per cycle. These
// steps follow from the single read port of the task-table and ready-queue RAMs.
// A result waits in an output register; the next event is accepted while it
// waits, and only the end of that next event stalls until rsp_tready.
// Reset (synchronous) empties every ready queue, frees all task slots and
// leaves the idle task running. RAM contents are not cleared.
`include "assert_macros.svh"

module priority_task_scheduler #(
   parameter int NUM_TASKS  = 8,
   parameter int NUM_LEVELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // task_slot[2:0], priority_req[10:3], delay_ticks[26:11]
   input  logic [2:0]  req_tuser,  // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // running_task[2:0], running_idle[3], new_slot[6:4],
                                   // status[8:7]
);

   localparam int SLOT_W = $clog2(NUM_TASKS);
   localparam int LVL_W  = $clog2(NUM_LEVELS);
   localparam int CNT_W  = $clog2(NUM_TASKS + 1);
   localparam int TW     = LVL_W + pts_pkg::MODE_W + pts_pkg::SLEEP_W;
   localparam int RA_W   = LVL_W + SLOT_W;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
   localparam logic [ST_W-1:0] S_DEC     = 4'd1;
   localparam logic [ST_W-1:0] S_TK_RD   = 4'd2;
   localparam logic [ST_W-1:0] S_TK_WR   = 4'd3;
   localparam logic [ST_W-1:0] S_RQ_RD   = 4'd4;
   localparam logic [ST_W-1:0] S_RQ_WR   = 4'd5;
   localparam logic [ST_W-1:0] S_DS_SCAN = 4'd6;
   localparam logic [ST_W-1:0] S_DS_RD   = 4'd7;
   localparam logic [ST_W-1:0] S_DS_WR   = 4'd8;
   localparam logic [ST_W-1:0] S_DL_WR   = 4'd9;
   localparam logic [ST_W-1:0] S_SR_CHK  = 4'd10;
   localparam logic [ST_W-1:0] S_RM_RD   = 4'd11;
   localparam logic [ST_W-1:0] S_RM_WR   = 4'd12;
   localparam logic [ST_W-1:0] S_DONE    = 4'd13;

   function automatic logic [SLOT_W-1:0] wrap_next(input logic [SLOT_W-1:0] p);
      logic [SLOT_W-1:0] r;
      r = (p == SLOT_W'(NUM_TASKS - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   // control
   logic [ST_W-1:0]   state_ff, state_in;
   logic [CNT_W-1:0]  added_ff, added_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic              idle_ff, idle_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] head_ff [NUM_LEVELS];
   logic [SLOT_W-1:0] head_in [NUM_LEVELS];
   logic [SLOT_W-1:0] tail_ff [NUM_LEVELS];
   logic [SLOT_W-1:0] tail_in [NUM_LEVELS];
   logic [CNT_W-1:0]  cnt_ff  [NUM_LEVELS];
   logic [CNT_W-1:0]  cnt_in  [NUM_LEVELS];

   // working registers
   logic [pts_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [2:0]                   slot_ff, slot_in;
   logic [7:0]                   prio_ff, prio_in;
   logic [pts_pkg::SLEEP_W-1:0]  dly_ff, dly_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;
   logic [LVL_W-1:0]             lvl_ff, lvl_in;
   logic [SLOT_W-1:0]            rd_ff, rd_in;
   logic [SLOT_W-1:0]            wr_ff, wr_in;
   logic [CNT_W-1:0]             n_ff, n_in;
   logic [CNT_W-1:0]             kept_ff, kept_in;
   logic [pts_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [2:0]                   newslot_ff, newslot_in;
   logic [15:0]                  rsp_data_ff, rsp_data_in;

   // RAM ports
   logic              t_we, t_re;
   logic [SLOT_W-1:0] t_waddr, t_raddr;
   logic [TW-1:0]     t_wdata, t_rdata;
   logic              r_we, r_re;
   logic [RA_W-1:0]   r_waddr, r_raddr;
   logic [SLOT_W-1:0] r_wdata, r_rdata;

   logic [LVL_W-1:0]            t_level;
   logic [pts_pkg::MODE_W-1:0]  t_mode;
   logic [pts_pkg::SLEEP_W-1:0] t_sleep;
   logic [31:0]                 slot32, prio32, added32, cur32;
   logic [SLOT_W-1:0]           slot_idx;
   logic                        slot_ok;
   logic [LVL_W-1:0]            lvl_clamp, sel_lvl;
   logic [SLOT_W-1:0]           head_sel, tail_sel;
   logic [CNT_W-1:0]            cnt_sel;
   logic                        push_en;
   logic [SLOT_W-1:0]           push_val;
   logic [2:0]                  run_task;
   logic                        req_fire;

   pts_ram #(.DATA_W(TW), .ADDR_W(SLOT_W)) u_task_ram (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
   );

   pts_ram #(.DATA_W(SLOT_W), .ADDR_W(RA_W)) u_ready_ram (
      .clock(clock), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
      .re(r_re), .raddr(r_raddr), .rdata(r_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign t_level = t_rdata[TW-1 -: LVL_W];
   assign t_mode  = t_rdata[pts_pkg::SLEEP_W +: pts_pkg::MODE_W];
   assign t_sleep = t_rdata[pts_pkg::SLEEP_W-1:0];

   assign slot32   = 32'(slot_ff);
   assign slot_idx = slot32[SLOT_W-1:0];
   assign added32  = 32'(added_ff);
   assign slot_ok  = slot32 < added32;
   assign prio32   = 32'(prio_ff);
   assign cur32    = 32'(cur_ff);
   assign run_task = idle_ff ? 3'd0 : cur32[2:0];

   always_comb begin
      if (prio_ff == 8'd0) begin
         lvl_clamp = LVL_W'(1);
      end else if (prio32 > 32'(NUM_LEVELS - 1)) begin
         lvl_clamp = LVL_W'(NUM_LEVELS - 1);
      end else begin
         lvl_clamp = prio32[LVL_W-1:0];
      end
   end

   // one queue index per cycle: the level pushed to, or the working level
   always_comb begin
      unique case (state_ff) inside
         S_DEC:                       sel_lvl = lvl_clamp;
         S_TK_WR, S_RQ_WR, S_SR_CHK:  sel_lvl = t_level;
         default:                     sel_lvl = lvl_ff;
      endcase
   end

   assign head_sel = head_ff[sel_lvl];
   assign tail_sel = tail_ff[sel_lvl];
   assign cnt_sel  = cnt_ff[sel_lvl];

   always_comb begin
      state_in     = state_ff;
      added_in     = added_ff;
      cur_in       = cur_ff;
      idle_in      = idle_ff;
      rsp_valid_in = rsp_valid_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      slot_in      = slot_ff;
      prio_in      = prio_ff;
      dly_in       = dly_ff;
      idx_in       = idx_ff;
      lvl_in       = lvl_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      n_in         = n_ff;
      kept_in      = kept_ff;
      status_in    = status_ff;
      newslot_in   = newslot_ff;
      rsp_data_in  = rsp_data_ff;
      t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_re = 1'b0; t_raddr = '0;
      r_we = 1'b0; r_waddr = '0; r_wdata = '0; r_re = 1'b0; r_raddr = '0;
      push_en  = 1'b0;
      push_val = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in    = req_tuser;
               slot_in    = req_tdata[2:0];
               prio_in    = req_tdata[10:3];
               dly_in     = req_tdata[26:11];
               status_in  = pts_pkg::STATUS_OK;
               newslot_in = 3'd0;
               state_in   = S_DEC;
            end
         end
         S_DEC: begin
            unique case (kind_ff) inside
               pts_pkg::KIND_TICK: begin
                  idx_in   = '0;
                  state_in = S_TK_RD;
               end
               pts_pkg::KIND_ADD: begin
                  if (added_ff == CNT_W'(NUM_TASKS)) begin
                     status_in = pts_pkg::STATUS_FULL;
                  end else begin
                     t_we       = 1'b1;
                     t_waddr    = added_ff[SLOT_W-1:0];
                     t_wdata    = {lvl_clamp, pts_pkg::MODE_QUEUED, 16'd0};
                     push_en    = 1'b1;
                     push_val   = added_ff[SLOT_W-1:0];
                     added_in   = added_ff + 1'b1;
                     newslot_in = added32[2:0];
                  end
                  state_in = S_DONE;
               end
               pts_pkg::KIND_DELAY: begin
                  if (idle_ff) begin
                     status_in = pts_pkg::STATUS_NOEFF;
                     state_in  = S_DONE;
                  end else if (dly_ff == '0) begin
                     state_in = S_RQ_RD;
                  end else begin
                     t_re     = 1'b1;
                     t_raddr  = cur_ff;
                     state_in = S_DL_WR;
                  end
               end
               pts_pkg::KIND_SUSPEND, pts_pkg::KIND_RESUME: begin
                  if (!slot_ok) begin
                     status_in = pts_pkg::STATUS_NOEFF;
                     state_in  = S_DONE;
                  end else begin
                     t_re     = 1'b1;
                     t_raddr  = slot_idx;
                     state_in = S_SR_CHK;
                  end
               end
               default: begin
                  status_in = pts_pkg::STATUS_NOEFF;
                  state_in  = S_DONE;
               end
            endcase
         end
         S_TK_RD: begin
            if (idx_ff == added_ff) begin
               state_in = S_RQ_RD;
            end else begin
               t_re     = 1'b1;
               t_raddr  = idx_ff[SLOT_W-1:0];
               state_in = S_TK_WR;
            end
         end
         S_TK_WR: begin
            if (t_mode == pts_pkg::MODE_SLEEPING) begin
               t_we    = 1'b1;
               t_waddr = idx_ff[SLOT_W-1:0];
               if (t_sleep <= 16'd1) begin
                  t_wdata  = {t_level, pts_pkg::MODE_QUEUED, 16'd0};
                  push_en  = 1'b1;
                  push_val = idx_ff[SLOT_W-1:0];
               end else begin
                  t_wdata = {t_level, pts_pkg::MODE_SLEEPING, t_sleep - 16'd1};
               end
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_TK_RD;
         end
         S_RQ_RD: begin
            lvl_in = LVL_W'(1);
            if (idle_ff) begin
               state_in = S_DS_SCAN;
            end else begin
               t_re     = 1'b1;
               t_raddr  = cur_ff;
               state_in = S_RQ_WR;
            end
         end
         S_RQ_WR: begin
            t_we     = 1'b1;
            t_waddr  = cur_ff;
            t_wdata  = {t_level, pts_pkg::MODE_QUEUED, t_sleep};
            push_en  = 1'b1;
            push_val = cur_ff;
            state_in = S_DS_SCAN;
         end
         S_DS_SCAN: begin
            if (cnt_sel != '0) begin
               r_re     = 1'b1;
               r_raddr  = {lvl_ff, head_sel};
               state_in = S_DS_RD;
            end else if (lvl_ff == LVL_W'(NUM_LEVELS - 1)) begin
               idle_in  = 1'b1;
               cur_in   = '0;
               state_in = S_DONE;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         S_DS_RD: begin
            head_in[lvl_ff] = wrap_next(head_sel);
            cnt_in[lvl_ff]  = cnt_sel - 1'b1;
            cur_in          = r_rdata;
            idle_in         = 1'b0;
            t_re            = 1'b1;
            t_raddr         = r_rdata;
            state_in        = S_DS_WR;
         end
         S_DS_WR: begin
            t_we     = 1'b1;
            t_waddr  = cur_ff;
            t_wdata  = {t_level, pts_pkg::MODE_RUNNING, t_sleep};
            state_in = S_DONE;
         end
         S_DL_WR: begin
            t_we     = 1'b1;
            t_waddr  = cur_ff;
            t_wdata  = {t_level, pts_pkg::MODE_SLEEPING, dly_ff};
            lvl_in   = LVL_W'(1);
            state_in = S_DS_SCAN;
         end
         S_SR_CHK: begin
            state_in = S_DONE;
            if (kind_ff == pts_pkg::KIND_SUSPEND) begin
               if (t_mode == pts_pkg::MODE_QUEUED) begin
                  t_we     = 1'b1;
                  t_waddr  = slot_idx;
                  t_wdata  = {t_level, pts_pkg::MODE_SUSPENDED, t_sleep};
                  lvl_in   = t_level;
                  rd_in    = head_sel;
                  wr_in    = head_sel;
                  n_in     = cnt_sel;
                  kept_in  = '0;
                  state_in = S_RM_RD;
               end else begin
                  status_in = pts_pkg::STATUS_NOEFF;
               end
            end else begin
               if (t_mode == pts_pkg::MODE_SUSPENDED) begin
                  t_we     = 1'b1;
                  t_waddr  = slot_idx;
                  t_wdata  = {t_level, pts_pkg::MODE_QUEUED, t_sleep};
                  push_en  = 1'b1;
                  push_val = slot_idx;
               end else begin
                  status_in = pts_pkg::STATUS_NOEFF;
               end
            end
         end
         S_RM_RD: begin
            // compact the queue in place, dropping the suspended slot
            if (n_ff == '0) begin
               tail_in[lvl_ff] = wr_ff;
               cnt_in[lvl_ff]  = kept_ff;
               state_in        = S_DONE;
            end else begin
               r_re     = 1'b1;
               r_raddr  = {lvl_ff, rd_ff};
               rd_in    = wrap_next(rd_ff);
               n_in     = n_ff - 1'b1;
               state_in = S_RM_WR;
            end
         end
         S_RM_WR: begin
            if (r_rdata != slot_idx) begin
               r_we    = 1'b1;
               r_waddr = {lvl_ff, wr_ff};
               r_wdata = r_rdata;
               wr_in   = wrap_next(wr_ff);
               kept_in = kept_ff + 1'b1;
            end
            state_in = S_RM_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, status_ff, newslot_ff, idle_ff, run_task};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push_en) begin
         r_we             = 1'b1;
         r_waddr          = {sel_lvl, tail_sel};
         r_wdata          = push_val;
         tail_in[sel_lvl] = wrap_next(tail_sel);
         cnt_in[sel_lvl]  = cnt_sel + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         added_ff     <= '0;
         cur_ff       <= '0;
         idle_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         added_ff     <= added_in;
         cur_ff       <= cur_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      slot_ff     <= slot_in;
      prio_ff     <= prio_in;
      dly_ff      <= dly_in;
      idx_ff      <= idx_in;
      lvl_ff      <= lvl_in;
      rd_ff       <= rd_in;
      wr_ff       <= wr_in;
      n_ff        <= n_in;
      kept_ff     <= kept_in;
      status_ff   <= status_in;
      newslot_ff  <= newslot_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, state_ff == S_DEC)
   `ASSERT_IMPL(a_idle_reports_zero, clock, reset, rsp_valid_ff && rsp_data_ff[3],
                rsp_data_ff[2:0] == 3'd0)
   `ASSERT_IMPL(a_added_bound, clock, reset, 1'b1, 32'(added_ff) <= NUM_TASKS)
   `ASSERT_IMPL(a_queue_bound, clock, reset, 1'b1, 32'(cnt_sel) <= NUM_TASKS)

endmodule
